FILE: hw/rtl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// shared constants, command codes and inter-module types for the
// fixed block free list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

    localparam int MAX_BLOCKS = 255;
    localparam int IDX_W      = 8;
    localparam int OFS_W      = 18;
    localparam int SIZE_W     = 11;
    localparam int CNT_W      = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CMD_W      = 2;
    localparam int DIV_CNT_W  = $clog2(OFS_W + 1);

    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd1;

    typedef struct packed {
        logic              start;
        logic [OFS_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [OFS_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fbfl_link_ram.sv
// ----------------------------------------------------------------------------
// fbfl_link_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_link_ram #(
    parameter int DEPTH  = 255,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fbfl_divider.sv
// ----------------------------------------------------------------------------
// fbfl_divider
// restoring divider, one quotient bit per cycle, offset over block size
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fbfl_pkg::div_req_t req,
    output fbfl_pkg::div_rsp_t      rsp
);
    import fbfl_pkg::*;

    logic                  run_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [OFS_W-1:0]      quo_reg;
    logic [SIZE_W-1:0]     rem_reg;
    logic [SIZE_W-1:0]     dvs_reg;

    logic [SIZE_W:0]       trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[OFS_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(OFS_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[OFS_W-2:0], fits};
            rem_reg <= fits ? SIZE_W'(trial - {1'b0, dvs_reg}) : trial[SIZE_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// free list allocator for one chunk of equal blocks, links held in a ram
// ----------------------------------------------------------------------------
//
// channel   | handshake         | payload
// ----------+-------------------+------------------------------------------
// request   | start, busy       | cmd, offset
// result    | done (strobe)     | result_offset, status, is_free, free_count
// config    | cfg_we            | cfg_index, cfg_data
//
// steps from accept to done: alloc does one link ram read, init writes one link
// a cycle for each block, free runs the bit-serial divider, query runs the divider
// and then, if anything is free, walks the free list with a ram read then a compare
// for each free block walked past.
// alloc that runs out and init of zero blocks show done in the next cycle.
// reset is asynchronous and clears head, count and control; the link ram is
// not cleared, init writes it.
// results show for one cycle; the next request may be taken while done shows.
`default_nettype none

module fixed_block_free_list_allocator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [fbfl_pkg::CMD_W-1:0]        cmd,
    input  wire logic [fbfl_pkg::OFS_W-1:0]        offset,
    output logic                                   done,
    output logic      [fbfl_pkg::OFS_W-1:0]        result_offset,
    output logic                                   status,
    output logic                                   is_free,
    output logic      [fbfl_pkg::CNT_W-1:0]        free_count,
    input  wire logic                              cfg_we,
    input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fbfl_pkg::CFG_W-1:0]        cfg_data
);
    import fbfl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_ALLOC = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_QCHK  = 3'd4;
    localparam logic [2:0] ST_QWAIT = 3'd5;

    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BLOCKS);

    // control state
    logic [2:0]        state_reg,  state_next;
    logic [IDX_W-1:0]  head_reg,   head_next;
    logic [CNT_W-1:0]  avail_reg,  avail_next;
    logic [CMD_W-1:0]  cmd_reg,    cmd_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [CNT_W-1:0]  lim_reg,    lim_next;
    logic              oob_reg,    oob_next;
    logic              done_reg,   done_next;
    logic [CNT_W-1:0]  bcount_reg;
    logic [SIZE_W-1:0] bsize_reg;

    // payload
    logic [OFS_W-1:0]  target_reg, target_next;
    logic [IDX_W-1:0]  cur_reg,    cur_next;
    logic [OFS_W-1:0]  prod_reg,   prod_next;
    logic [OFS_W-1:0]  res_reg,    res_next;
    logic              stat_reg,   stat_next;
    logic              hit_reg,    hit_next;

    // link ram ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [IDX_W-1:0]  ram_rdata;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [SIZE_W-1:0] eff_size;
    logic [CNT_W-1:0]  init_n;
    logic [IDX_W-1:0]  link_val;
    logic [IDX_W+SIZE_W-1:0] prod_full;

    // a block size of zero counts as one
    assign eff_size = (bsize_reg == '0) ? SIZE_W'(1) : bsize_reg;
    // init never chains more blocks than the ram holds
    assign init_n   = (bcount_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : bcount_reg;
    // links beyond the ram read as zero
    assign link_val = oob_reg ? '0 : ram_rdata;
    // full width product, the offset keeps its low bits
    assign prod_full = {{SIZE_W{1'b0}}, head_reg} * {{IDX_W{1'b0}}, eff_size};

    fbfl_link_ram #(
        .DEPTH  (MAX_BLOCKS),
        .WIDTH  (IDX_W),
        .ADDR_W (IDX_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbfl_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        avail_next   = avail_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        lim_next     = lim_reg;
        oob_next     = oob_reg;
        done_next    = 1'b0;
        target_next  = target_reg;
        cur_next     = cur_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        stat_next    = stat_reg;
        hit_next     = hit_reg;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg;
        ram_wdata    = cnt_reg + 1'b1;
        ram_re       = 1'b0;
        ram_raddr    = head_reg;
        div_req.start    = 1'b0;
        div_req.dividend = offset;
        div_req.divisor  = eff_size;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    case (cmd)
                        CMD_INIT:
                        begin
                            if (init_n == '0)
                            begin
                                // empty chunk: done at once, nothing free
                                head_next  = '0;
                                avail_next = '0;
                                done_next  = 1'b1;
                                res_next   = '0;
                                stat_next  = 1'b0;
                                hit_next   = 1'b0;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                lim_next   = init_n - 1'b1;
                                state_next = ST_INIT;
                            end
                        end
                        CMD_ALLOC:
                        begin
                            if (avail_reg == '0)
                            begin
                                done_next = 1'b1;
                                res_next  = '0;
                                stat_next = 1'b1;
                                hit_next  = 1'b0;
                            end
                            else
                            begin
                                prod_next  = prod_full[OFS_W-1:0];
                                ram_raddr  = head_reg;
                                ram_re     = head_reg < MAX_IDX;
                                oob_next   = !(head_reg < MAX_IDX);
                                state_next = ST_ALLOC;
                            end
                        end
                        default:
                        begin
                            // free and query both need offset / block size
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                // chain block i to block i+1
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = cnt_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == lim_reg)
                begin
                    head_next  = '0;
                    avail_next = lim_reg + 1'b1;
                    done_next  = 1'b1;
                    res_next   = '0;
                    stat_next  = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                // pop the head
                head_next  = link_val;
                avail_next = avail_reg - 1'b1;
                done_next  = 1'b1;
                res_next   = prod_reg;
                stat_next  = 1'b0;
                hit_next   = 1'b0;
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (cmd_reg == CMD_FREE)
                    begin
                        // push: no check for double release; an out-of-range block skips the link write
                        ram_we     = div_rsp.quotient < OFS_W'(MAX_BLOCKS);
                        ram_waddr  = div_rsp.quotient[IDX_W-1:0];
                        ram_wdata  = head_reg;
                        head_next  = div_rsp.quotient[IDX_W-1:0];
                        avail_next = avail_reg + 1'b1;
                        done_next  = 1'b1;
                        res_next   = '0;
                        stat_next  = 1'b0;
                        hit_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        target_next = div_rsp.quotient;
                        cur_next    = head_reg;
                        cnt_next    = avail_reg;
                        if (avail_reg == '0)
                        begin
                            done_next  = 1'b1;
                            res_next   = '0;
                            stat_next  = 1'b0;
                            hit_next   = 1'b0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_QCHK;
                        end
                    end
                end
            end
            ST_QCHK:
            begin
                // cnt_reg holds the entries left including the current one
                if (OFS_W'(cur_reg) == target_reg)
                begin
                    done_next  = 1'b1;
                    res_next   = '0;
                    stat_next  = 1'b0;
                    hit_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    res_next   = '0;
                    stat_next  = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_raddr  = cur_reg;
                    ram_re     = cur_reg < MAX_IDX;
                    oob_next   = !(cur_reg < MAX_IDX);
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_QWAIT;
                end
            end
            ST_QWAIT:
            begin
                cur_next   = link_val;
                state_next = ST_QCHK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            avail_reg <= '0;
            cmd_reg   <= CMD_INIT;
            cnt_reg   <= '0;
            lim_reg   <= '0;
            oob_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            avail_reg <= avail_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            lim_reg   <= lim_next;
            oob_reg   <= oob_next;
            done_reg  <= done_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg <= CNT_W'(255);
            bsize_reg  <= SIZE_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_COUNT: bcount_reg <= cfg_data[CNT_W-1:0];
                CFG_BLOCK_SIZE:  bsize_reg  <= cfg_data[SIZE_W-1:0];
                default:         bsize_reg  <= bsize_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        cur_reg    <= cur_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        stat_reg   <= stat_next;
        hit_reg    <= hit_next;
    end

    assign busy          = state_reg != ST_IDLE;
    assign done          = done_reg;
    assign result_offset = res_reg;
    assign status        = stat_reg;
    assign is_free       = hit_reg;
    // count is already updated when done shows
    assign free_count    = avail_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fbfl_checker.sv
// ----------------------------------------------------------------------------
// fbfl_checker
// port-level checks on the allocator, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       done,
    input wire logic [fbfl_pkg::OFS_W-1:0] result_offset,
    input wire logic                       status,
    input wire logic                       is_free,
    input wire logic [fbfl_pkg::CNT_W-1:0] free_count
);
    import fbfl_pkg::*;

    // an accepted request either completes next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither busy nor done");

    // busy only starts from an accepted request
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // a result only shows once the block is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // run out means nothing free and no offset
    a_run_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (result_offset == '0 && free_count == '0 && !is_free))
        else $error("inconsistent run out result");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .result_offset (result_offset),
    .status        (status),
    .is_free       (is_free),
    .free_count    (free_count)
);

`default_nettype wire
